// File: rtl/executable_header_classifier_core_macros.svh
// Assertion macros for the executable header classifier checker.
`ifndef EXECUTABLE_HEADER_CLASSIFIER_CORE_MACROS_SVH
`define EXECUTABLE_HEADER_CLASSIFIER_CORE_MACROS_SVH

// Same-cycle implication, masked during reset.
`define EHC_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ehc implication check failed");

// Next-cycle implication, masked during reset.
`define EHC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ehc next-cycle check failed");

// Behavior right after a reset cycle.
`define EHC_ASSERT_AFTER_RESET(label, cons) \
  label: assert property (@(posedge clk) rst |=> (cons)) \
    else $error("ehc reset check failed");

`endif

// File: rtl/ehc_pkg.sv
// Types and constants for the executable header classifier.
package ehc_pkg;

  localparam int unsigned HEAD_LEN   = 20;
  localparam int unsigned COUNT_W    = 21;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic [COUNT_W-1:0] PE_PTR_POS = 21'h3C;
  localparam logic [COUNT_W-1:0] PE_MIN_OFF = 21'd64;
  localparam logic [31:0] PE_MIN_OFF32 = 32'd64;
  localparam logic [COUNT_W-1:0] PE_WIN_LEN = 21'd6;
  localparam logic [2:0] PE_WIN_LAST = 3'd5;

  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = 1;
  localparam int unsigned QCNT_W = 2;

  localparam logic [2:0] FMT_NONE     = 3'd0;
  localparam logic [2:0] FMT_ELF      = 3'd1;
  localparam logic [2:0] FMT_PE       = 3'd2;
  localparam logic [2:0] FMT_MACHO    = 3'd3;
  localparam logic [2:0] FMT_MACHO_FAT = 3'd4;

  localparam logic [2:0] ISA_NONE  = 3'd0;
  localparam logic [2:0] ISA_IA32  = 3'd1;
  localparam logic [2:0] ISA_AMD64 = 3'd2;
  localparam logic [2:0] ISA_ARM32 = 3'd3;
  localparam logic [2:0] ISA_A64   = 3'd4;
  localparam logic [2:0] ISA_RV32  = 3'd5;
  localparam logic [2:0] ISA_RV64  = 3'd6;

  localparam logic [6:0] BITS_NONE = 7'd0;
  localparam logic [6:0] BITS_32   = 7'd32;
  localparam logic [6:0] BITS_64   = 7'd64;

  localparam logic [7:0] ELF_MAG0 = 8'h7f;
  localparam logic [7:0] ELF_MAG1 = 8'h45;
  localparam logic [7:0] ELF_MAG2 = 8'h4c;
  localparam logic [7:0] ELF_MAG3 = 8'h46;
  localparam logic [7:0] ELF_CLASS64 = 8'd2;
  localparam logic [7:0] ELF_DATA_LE = 8'd1;
  localparam logic [15:0] ELF_M_386   = 16'd3;
  localparam logic [15:0] ELF_M_AMD64 = 16'd62;
  localparam logic [15:0] ELF_M_ARM   = 16'd40;
  localparam logic [15:0] ELF_M_A64   = 16'd183;
  localparam logic [15:0] ELF_M_RV    = 16'd243;

  localparam logic [7:0] MZ_MAG0 = 8'h4d;
  localparam logic [7:0] MZ_MAG1 = 8'h5a;
  localparam logic [31:0] PE_SIG = 32'h0000_4550;
  localparam logic [15:0] PE_M_I386  = 16'h014c;
  localparam logic [15:0] PE_M_AMD64 = 16'h8664;
  localparam logic [15:0] PE_M_ARM   = 16'h01c0;
  localparam logic [15:0] PE_M_ARM64 = 16'haa64;

  localparam logic [31:0] MH_MAGIC     = 32'hFEEDFACE;
  localparam logic [31:0] MH_MAGIC_64  = 32'hFEEDFACF;
  localparam logic [31:0] MH_CIGAM     = 32'hCEFAEDFE;
  localparam logic [31:0] MH_CIGAM_64  = 32'hCFFAEDFE;
  localparam logic [31:0] FAT_MAGIC    = 32'hCAFEBABE;
  localparam logic [31:0] FAT_CIGAM    = 32'hBEBAFECA;
  localparam logic [31:0] CPU_X86      = 32'd7;
  localparam logic [31:0] CPU_ARM      = 32'd12;
  localparam logic [31:0] CPU_X86_64   = 32'h0100_0007;
  localparam logic [31:0] CPU_ARM64    = 32'h0100_000C;

  typedef logic [HEAD_LEN-1:0][7:0] head_t;

  // Everything the back end needs to classify one finished file.
  typedef struct packed {
    head_t       head;
    logic        has8;
    logic        has20;
    logic        pe_done;
    logic [47:0] pe_window;
  } snap_t;

  typedef struct packed {
    logic        found;
    logic [2:0]  format_code;
    logic [2:0]  arch_code;
    logic [6:0]  word_bits;
    logic        little_endian;
    logic [31:0] machine_value;
  } verdict_t;

endpackage

// File: rtl/ehc_channels.sv
// Valid/ready channel interfaces for file bytes and verdicts.
interface ehc_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;
  modport source(output valid, output data_byte, output last_byte, input ready);
  modport sink(input valid, input data_byte, input last_byte, output ready);
endinterface

interface ehc_verdict_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic [2:0]  format_code;
  logic [2:0]  arch_code;
  logic [6:0]  word_bits;
  logic        little_endian;
  logic [31:0] machine_value;
  modport source(output valid, output found, output format_code, output arch_code,
                 output word_bits, output little_endian, output machine_value,
                 input ready);
  modport sink(input valid, input found, input format_code, input arch_code,
               input word_bits, input little_endian, input machine_value,
               output ready);
endinterface

// File: rtl/executable_header_classifier_core.sv
// Top level of the executable header classifier.
//
//   channel     dir  handshake     payload
//   file_bytes  in   valid/ready   data_byte, last_byte
//   verdicts    out  valid/ready   found, format_code, arch_code, word_bits,
//                                  little_endian, machine_value
//
// One byte per cycle; ready drops only while the two-entry snapshot queue is full.
// A verdict passes from its last byte through the queue write, then the
// classifier register. Synchronous reset clears counts, queue and output valid.
// A stalled verdict output backs up into the queue, then into byte intake.
module executable_header_classifier_core
  import ehc_pkg::*;
#(
  parameter int unsigned PE_OFFSET_LIMIT = 1048576
) (
  input  logic          clk,
  input  logic          rst,
  ehc_byte_if.sink      file_bytes,
  ehc_verdict_if.source verdicts
);

  logic     take, push, full, pop, empty;
  snap_t    snap, q_head;
  verdict_t verdict;

  assign file_bytes.ready = !full;
  assign take = file_bytes.valid && file_bytes.ready;

  ehc_front #(
    .PE_OFFSET_LIMIT(PE_OFFSET_LIMIT)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .take     (take),
    .data_byte(file_bytes.data_byte),
    .last_byte(file_bytes.last_byte),
    .push     (push),
    .snap     (snap)
  );

  ehc_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_data(snap),
    .full     (full),
    .pop      (pop),
    .empty    (empty),
    .head_data(q_head)
  );

  ehc_back u_back (
    .clk      (clk),
    .rst      (rst),
    .empty    (empty),
    .snap     (q_head),
    .pop      (pop),
    .out_valid(verdicts.valid),
    .out_ready(verdicts.ready),
    .verdict  (verdict)
  );

  assign verdicts.found         = verdict.found;
  assign verdicts.format_code   = verdict.format_code;
  assign verdicts.arch_code     = verdict.arch_code;
  assign verdicts.word_bits     = verdict.word_bits;
  assign verdicts.little_endian = verdict.little_endian;
  assign verdicts.machine_value = verdict.machine_value;

endmodule

// File: rtl/ehc_front.sv
// Byte capture: head bytes, PE pointer and PE window; emits a snapshot per file.
module ehc_front
  import ehc_pkg::*;
#(
  parameter int unsigned PE_OFFSET_LIMIT = 1048576
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       take,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  output logic       push,
  output snap_t      snap
);

  logic [COUNT_W-1:0] byte_count, byte_count_next;
  head_t              head_bytes, head_bytes_next;
  logic [31:0]        pe_offset_word, pe_offset_word_next;
  logic [47:0]        pe_window, pe_window_next;
  logic               pe_done, pe_done_next;

  logic               pe_ok;
  logic [COUNT_W-1:0] off21;
  logic [COUNT_W-1:0] win_idx;
  logic               in_win;
  logic               live;

  assign live   = byte_count != COUNT_MAX;
  assign pe_ok  = (pe_offset_word >= PE_MIN_OFF32) &&
                  (pe_offset_word <= 32'(PE_OFFSET_LIMIT));
  assign off21  = pe_offset_word[COUNT_W-1:0];
  assign win_idx = byte_count - off21;
  assign in_win = pe_ok && (byte_count >= PE_MIN_OFF) && (byte_count >= off21) &&
                  (win_idx < PE_WIN_LEN);

  always_comb begin
    byte_count_next     = byte_count;
    head_bytes_next     = head_bytes;
    pe_offset_word_next = pe_offset_word;
    pe_window_next      = pe_window;
    pe_done_next        = pe_done;
    if (live) begin
      byte_count_next = byte_count + 1'b1;
      for (int i = 0; i < HEAD_LEN; i++) begin
        if (byte_count == COUNT_W'(i)) begin
          head_bytes_next[i] = data_byte;
        end
      end
      if (byte_count[COUNT_W-1:2] == PE_PTR_POS[COUNT_W-1:2]) begin
        pe_offset_word_next[byte_count[1:0]*8 +: 8] = data_byte;
      end
      if (in_win) begin
        pe_window_next[win_idx[2:0]*8 +: 8] = data_byte;
        if (win_idx[2:0] == PE_WIN_LAST) begin
          pe_done_next = 1'b1;
        end
      end
    end
  end

  always_comb begin
    snap.head      = head_bytes_next;
    snap.has8      = byte_count_next >= COUNT_W'(8);
    snap.has20     = byte_count_next >= COUNT_W'(HEAD_LEN);
    snap.pe_done   = pe_done_next;
    snap.pe_window = pe_window_next;
  end

  assign push = take && last_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
      pe_done    <= 1'b0;
    end else if (take) begin
      if (last_byte) begin
        byte_count <= '0;
        pe_done    <= 1'b0;
      end else begin
        byte_count <= byte_count_next;
        pe_done    <= pe_done_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      head_bytes     <= head_bytes_next;
      pe_offset_word <= pe_offset_word_next;
      pe_window      <= pe_window_next;
    end
  end

endmodule

// File: rtl/ehc_queue.sv
// Two-entry snapshot queue between capture and classification.
module ehc_queue
  import ehc_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  snap_t push_data,
  output logic  full,
  input  logic  pop,
  output logic  empty,
  output snap_t head_data
);

  snap_t             entries [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] fill;

  assign full      = fill == QCNT_W'(QDEPTH);
  assign empty     = fill == '0;
  assign head_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

// File: rtl/ehc_back.sv
// Format classification of one snapshot into a registered verdict.
module ehc_back
  import ehc_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     empty,
  input  snap_t    snap,
  output logic     pop,
  output logic     out_valid,
  input  logic     out_ready,
  output verdict_t verdict
);

  head_t       h;
  logic        is_elf, is_pe, has_macho;
  logic        elf_64, elf_le;
  logic [15:0] elf_m, pe_m;
  logic [31:0] magic, cpu_le, cpu_be;
  verdict_t    v;

  assign h        = snap.head;
  assign is_elf   = snap.has20 && h[0] == ELF_MAG0 && h[1] == ELF_MAG1 &&
                    h[2] == ELF_MAG2 && h[3] == ELF_MAG3;
  assign is_pe    = snap.pe_done && h[0] == MZ_MAG0 && h[1] == MZ_MAG1 &&
                    snap.pe_window[31:0] == PE_SIG;
  assign has_macho = snap.has8;
  assign elf_64   = h[4] == ELF_CLASS64;
  assign elf_le   = h[5] == ELF_DATA_LE;
  assign elf_m    = elf_le ? {h[19], h[18]} : {h[18], h[19]};
  assign pe_m     = snap.pe_window[47:32];
  assign magic    = {h[3], h[2], h[1], h[0]};
  assign cpu_le   = {h[7], h[6], h[5], h[4]};
  assign cpu_be   = {h[4], h[5], h[6], h[7]};

  always_comb begin
    v = '0;
    if (is_elf) begin
      v.found         = 1'b1;
      v.format_code   = FMT_ELF;
      v.word_bits     = elf_64 ? BITS_64 : BITS_32;
      v.little_endian = elf_le;
      v.machine_value = {16'd0, elf_m};
      unique case (elf_m)
        ELF_M_386:   v.arch_code = ISA_IA32;
        ELF_M_AMD64: v.arch_code = ISA_AMD64;
        ELF_M_ARM:   v.arch_code = ISA_ARM32;
        ELF_M_A64:   v.arch_code = ISA_A64;
        ELF_M_RV:    v.arch_code = elf_64 ? ISA_RV64 : ISA_RV32;
        default:     v.arch_code = ISA_NONE;
      endcase
    end else if (is_pe) begin
      v.found         = 1'b1;
      v.format_code   = FMT_PE;
      v.little_endian = 1'b1;
      v.machine_value = {16'd0, pe_m};
      unique case (pe_m)
        PE_M_I386: begin
          v.arch_code = ISA_IA32;
          v.word_bits = BITS_32;
        end
        PE_M_AMD64: begin
          v.arch_code = ISA_AMD64;
          v.word_bits = BITS_64;
        end
        PE_M_ARM: begin
          v.arch_code = ISA_ARM32;
          v.word_bits = BITS_32;
        end
        PE_M_ARM64: begin
          v.arch_code = ISA_A64;
          v.word_bits = BITS_64;
        end
        default: begin
          v.arch_code = ISA_NONE;
          v.word_bits = BITS_NONE;
        end
      endcase
    end else if (has_macho) begin
      unique case (magic) inside
        FAT_MAGIC, FAT_CIGAM: begin
          v.found       = 1'b1;
          v.format_code = FMT_MACHO_FAT;
        end
        MH_MAGIC: begin
          v.found         = 1'b1;
          v.format_code   = FMT_MACHO;
          v.word_bits     = BITS_32;
          v.little_endian = 1'b1;
          v.machine_value = cpu_le;
          v.arch_code     = (cpu_le == CPU_X86) ? ISA_IA32 :
                            (cpu_le == CPU_ARM) ? ISA_ARM32 : ISA_NONE;
        end
        MH_CIGAM: begin
          v.found         = 1'b1;
          v.format_code   = FMT_MACHO;
          v.word_bits     = BITS_32;
          v.machine_value = cpu_be;
        end
        MH_MAGIC_64: begin
          v.found         = 1'b1;
          v.format_code   = FMT_MACHO;
          v.word_bits     = BITS_64;
          v.little_endian = 1'b1;
          v.machine_value = cpu_le;
          v.arch_code     = (cpu_le == CPU_X86_64) ? ISA_AMD64 :
                            (cpu_le == CPU_ARM64) ? ISA_A64 : ISA_NONE;
        end
        MH_CIGAM_64: begin
          v.found       = 1'b1;
          v.format_code = FMT_MACHO;
          v.word_bits   = BITS_64;
        end
        default: v = '0;
      endcase
    end
  end

  assign pop = !empty && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      verdict <= v;
    end
  end

endmodule

// File: rtl/ehc_checker.sv
// Port-level checks for the executable header classifier, bound to the top level.
`include "executable_header_classifier_core_macros.svh"

module ehc_checker
  import ehc_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic        found,
  input logic [2:0]  format_code,
  input logic [2:0]  arch_code,
  input logic [6:0]  word_bits,
  input logic        little_endian,
  input logic [31:0] machine_value
);

  logic [46:0] payload;
  logic        stalled;
  logic        fields_zero;
  logic        bits_ok;
  logic        fat_plain;

  assign payload     = {found, format_code, arch_code, word_bits, little_endian,
                        machine_value};
  assign stalled     = out_valid && !out_ready;
  assign fields_zero = format_code == FMT_NONE && arch_code == ISA_NONE &&
                       word_bits == BITS_NONE && !little_endian &&
                       machine_value == 32'd0;
  assign bits_ok     = word_bits == BITS_NONE || word_bits == BITS_32 ||
                       word_bits == BITS_64;
  assign fat_plain   = found && arch_code == ISA_NONE && word_bits == BITS_NONE &&
                       machine_value == 32'd0;

  `EHC_ASSERT_AFTER_RESET(a_reset_idle, !out_valid)
  `EHC_ASSERT_NEXT(a_stall_hold, stalled, out_valid && $stable(payload))
  `EHC_ASSERT_IMPLY(a_fail_zero, out_valid && !found, fields_zero)
  `EHC_ASSERT_IMPLY(a_bits_legal, out_valid, bits_ok)
  `EHC_ASSERT_IMPLY(a_fat_plain, out_valid && format_code == FMT_MACHO_FAT, fat_plain)

endmodule

bind executable_header_classifier_core ehc_checker u_ehc_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (verdicts.valid),
  .out_ready    (verdicts.ready),
  .found        (verdicts.found),
  .format_code  (verdicts.format_code),
  .arch_code    (verdicts.arch_code),
  .word_bits    (verdicts.word_bits),
  .little_endian(verdicts.little_endian),
  .machine_value(verdicts.machine_value)
);

// File: tb/sv/ehc_verdict_checker.sv
// Checker for the header classifier: tracks file bytes, predicts and compares verdicts.
module ehc_verdict_checker
  import ehc_pkg::*;
#(
  parameter int unsigned PE_OFFSET_LIMIT = 1048576
) (
  input  logic        clk,
  input  logic        rst,
  ehc_byte_if         file_bytes,
  ehc_verdict_if      verdicts,
  output int unsigned fail_count,
  output int unsigned pending,
  output int unsigned checked
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [COUNT_W-1:0] seen;
  logic [7:0]         head [HEAD_LEN];
  logic [31:0]        pe_ptr;
  logic [47:0]        pe_win;
  verdict_t           verdicts_due [$];

  function automatic logic pe_ptr_ok(logic [31:0] ptr);
    return ptr >= PE_MIN_OFF32 && ptr <= PE_OFFSET_LIMIT;
  endfunction

  task automatic clear_file();
    seen = '0;
    for (int i = 0; i < HEAD_LEN; i++) head[i] = '0;
    pe_ptr = '0;
    pe_win = '0;
  endtask

  function automatic verdict_t classify_file();
    verdict_t    v;
    logic [31:0] magic;
    logic [31:0] cpu;
    logic [15:0] mach;
    logic [32:0] pe_end;
    v = '0;
    magic = {head[3], head[2], head[1], head[0]};
    cpu = {head[7], head[6], head[5], head[4]};
    pe_end = {1'b0, pe_ptr} + 33'(PE_WIN_LEN);
    if (seen >= HEAD_LEN && head[0] == ELF_MAG0 && head[1] == ELF_MAG1 &&
        head[2] == ELF_MAG2 && head[3] == ELF_MAG3) begin
      v.found = 1'b1;
      v.format_code = FMT_ELF;
      v.word_bits = (head[4] == ELF_CLASS64) ? BITS_64 : BITS_32;
      v.little_endian = (head[5] == ELF_DATA_LE);
      mach = v.little_endian ? {head[19], head[18]} : {head[18], head[19]};
      v.machine_value = {16'h0, mach};
      case (mach)
        ELF_M_386:   v.arch_code = ISA_IA32;
        ELF_M_AMD64: v.arch_code = ISA_AMD64;
        ELF_M_ARM:   v.arch_code = ISA_ARM32;
        ELF_M_A64:   v.arch_code = ISA_A64;
        ELF_M_RV:    v.arch_code = (v.word_bits == BITS_64) ? ISA_RV64 : ISA_RV32;
        default:     v.arch_code = ISA_NONE;
      endcase
    end else if (seen >= PE_MIN_OFF && head[0] == MZ_MAG0 && head[1] == MZ_MAG1 &&
                 pe_ptr_ok(pe_ptr) && {12'd0, seen} >= pe_end &&
                 pe_win[31:0] == PE_SIG) begin
      mach = pe_win[47:32];
      v.found = 1'b1;
      v.format_code = FMT_PE;
      v.little_endian = 1'b1;
      v.machine_value = {16'h0, mach};
      case (mach)
        PE_M_I386:  begin v.arch_code = ISA_IA32;  v.word_bits = BITS_32; end
        PE_M_AMD64: begin v.arch_code = ISA_AMD64; v.word_bits = BITS_64; end
        PE_M_ARM:   begin v.arch_code = ISA_ARM32; v.word_bits = BITS_32; end
        PE_M_ARM64: begin v.arch_code = ISA_A64;   v.word_bits = BITS_64; end
        default:    begin v.arch_code = ISA_NONE;  v.word_bits = BITS_NONE; end
      endcase
    end else if (seen >= 8) begin
      case (magic) inside
        FAT_MAGIC, FAT_CIGAM: begin
          v.found = 1'b1;
          v.format_code = FMT_MACHO_FAT;
        end
        MH_MAGIC: begin
          v.found = 1'b1;
          v.format_code = FMT_MACHO;
          v.word_bits = BITS_32;
          v.little_endian = 1'b1;
          v.machine_value = cpu;
          v.arch_code = (cpu == CPU_X86) ? ISA_IA32 :
                        (cpu == CPU_ARM) ? ISA_ARM32 : ISA_NONE;
        end
        MH_CIGAM: begin
          v.found = 1'b1;
          v.format_code = FMT_MACHO;
          v.word_bits = BITS_32;
          v.machine_value = {head[4], head[5], head[6], head[7]};
        end
        MH_MAGIC_64: begin
          v.found = 1'b1;
          v.format_code = FMT_MACHO;
          v.word_bits = BITS_64;
          v.little_endian = 1'b1;
          v.machine_value = cpu;
          v.arch_code = (cpu == CPU_X86_64) ? ISA_AMD64 :
                        (cpu == CPU_ARM64) ? ISA_A64 : ISA_NONE;
        end
        MH_CIGAM_64: begin
          v.found = 1'b1;
          v.format_code = FMT_MACHO;
          v.word_bits = BITS_64;
        end
        default: ;
      endcase
    end
    return v;
  endfunction

  task automatic capture_byte(logic [7:0] b, logic last);
    logic [32:0] rel;
    if (seen != COUNT_MAX) begin
      if (seen < HEAD_LEN) head[seen] = b;
      if (seen >= PE_PTR_POS && seen <= PE_PTR_POS + 3) pe_ptr[8*seen[1:0] +: 8] = b;
      rel = {12'd0, seen} - {1'b0, pe_ptr};
      if (seen >= PE_MIN_OFF && pe_ptr_ok(pe_ptr) && {12'd0, seen} >= {1'b0, pe_ptr} &&
          rel < 33'(PE_WIN_LEN))
        pe_win[8*rel[2:0] +: 8] = b;
      seen = seen + 1'b1;
    end
    if (last) begin
      verdicts_due.push_back(classify_file());
      clear_file();
    end
  endtask

  task automatic check_verdict();
    verdict_t got;
    verdict_t want;
    got.found = verdicts.found;
    got.format_code = verdicts.format_code;
    got.arch_code = verdicts.arch_code;
    got.word_bits = verdicts.word_bits;
    got.little_endian = verdicts.little_endian;
    got.machine_value = verdicts.machine_value;
    checked++;
    if (verdicts_due.size() == 0) begin
      fail_count++;
      if (fail_count <= 10)
        $display("ERROR %0t: verdict with none pending: %s",
                 $realtime, $sformatf("found=%0b fmt=%0d arch=%0d bits=%0d le=%0b mach=%h",
                 got.found, got.format_code, got.arch_code, got.word_bits,
                 got.little_endian, got.machine_value));
    end else begin
      want = verdicts_due.pop_front();
      if (got !== want) begin
        fail_count++;
        if (fail_count <= 10) begin
          $display("ERROR %0t: verdict %0d mismatch", $realtime, checked);
          $display("  expected found=%0b fmt=%0d arch=%0d bits=%0d le=%0b mach=%h",
                   want.found, want.format_code, want.arch_code, want.word_bits,
                   want.little_endian, want.machine_value);
          $display("  actual   found=%0b fmt=%0d arch=%0d bits=%0d le=%0b mach=%h",
                   got.found, got.format_code, got.arch_code, got.word_bits,
                   got.little_endian, got.machine_value);
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_file();
      verdicts_due.delete();
      fail_count = 0;
      checked = 0;
    end else begin
      if (verdicts.valid && verdicts.ready) check_verdict();
      if (file_bytes.valid && file_bytes.ready)
        capture_byte(file_bytes.data_byte, file_bytes.last_byte);
    end
    pending = verdicts_due.size();
  end

endmodule

// File: tb/sv/tb.sv
// Testbench top: streams directed and random file images into the classifier.
module tb;
  import ehc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned PE_LIMIT = 1048576;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned BYTE_TARGET = 1700;
  localparam int unsigned FILE_TARGET = 45;
  localparam logic [7:0] ELF_CLASS32 = 8'd1;
  localparam logic [7:0] ELF_DATA_BE = 8'd2;

  logic clk;
  logic rst;

  ehc_byte_if    file_bytes ();
  ehc_verdict_if verdicts ();

  int unsigned fail_count;
  int unsigned pending;
  int unsigned checked;

  executable_header_classifier_core #(.PE_OFFSET_LIMIT(PE_LIMIT)) DUT (
    .clk        (clk),
    .rst        (rst),
    .file_bytes (file_bytes),
    .verdicts   (verdicts)
  );

  ehc_verdict_checker #(.PE_OFFSET_LIMIT(PE_LIMIT)) u_verdict_check (
    .clk        (clk),
    .rst        (rst),
    .file_bytes (file_bytes),
    .verdicts   (verdicts),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked)
  );

  logic [15:0] elf_machines [5] = '{ELF_M_386, ELF_M_AMD64, ELF_M_ARM, ELF_M_A64, ELF_M_RV};
  logic [15:0] pe_machines [4] = '{PE_M_I386, PE_M_AMD64, PE_M_ARM, PE_M_ARM64};
  logic [31:0] macho_magics [6] = '{MH_MAGIC, MH_MAGIC_64, MH_CIGAM, MH_CIGAM_64,
                                    FAT_MAGIC, FAT_CIGAM};
  logic [31:0] macho_cpus [4] = '{CPU_X86, CPU_ARM, CPU_X86_64, CPU_ARM64};

  logic [7:0]  img [$];
  int unsigned burst_left = 0;
  int unsigned files_sent = 0;
  int unsigned bytes_sent = 0;
  int unsigned rx_left = 0;
  int unsigned rx_mode = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // receiver: alternates between always-ready, random and mostly-stalled stretches
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode <= $urandom_range(0, 2);
      rx_left <= $urandom_range(20, 200);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      0:       verdicts.ready <= 1'b1;
      1:       verdicts.ready <= 1'($urandom_range(0, 1));
      default: verdicts.ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  task automatic put(longint idx, logic [7:0] val);
    if (idx >= 0 && idx < img.size()) img[idx] = val;
  endtask

  task automatic fill_random(int len);
    img.delete();
    for (int i = 0; i < len; i++) img.push_back(8'($urandom));
  endtask

  task automatic make_elf(logic [7:0] cls, logic [7:0] order, logic [15:0] mach, int len);
    fill_random(len);
    put(0, ELF_MAG0);
    put(1, ELF_MAG1);
    put(2, ELF_MAG2);
    put(3, ELF_MAG3);
    put(4, cls);
    put(5, order);
    put(18, (order == ELF_DATA_LE) ? mach[7:0] : mach[15:8]);
    put(19, (order == ELF_DATA_LE) ? mach[15:8] : mach[7:0]);
  endtask

  task automatic make_pe(logic [31:0] ptr, logic [15:0] mach, int len);
    fill_random(len);
    for (int k = 0; k < 4; k++) put(longint'(ptr) + k, PE_SIG[8*k +: 8]);
    put(longint'(ptr) + 4, mach[7:0]);
    put(longint'(ptr) + 5, mach[15:8]);
    for (int k = 0; k < 4; k++) put(PE_PTR_POS + k, ptr[8*k +: 8]);
    put(0, MZ_MAG0);
    put(1, MZ_MAG1);
  endtask

  task automatic make_macho(logic [31:0] magic, logic [31:0] cpu, int len);
    fill_random(len);
    for (int k = 0; k < 4; k++) begin
      put(k, magic[8*k +: 8]);
      put(4 + k, cpu[8*k +: 8]);
    end
  endtask

  task automatic send_file();
    int gap;
    for (int i = 0; i < img.size(); i++) begin
      if (burst_left == 0) begin
        gap = $urandom_range(1, 6);
        repeat (gap) begin
          @(negedge clk);
          file_bytes.valid <= 1'b0;
        end
        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200) :
                                                   $urandom_range(1, 12);
      end
      @(negedge clk);
      file_bytes.valid <= 1'b1;
      file_bytes.data_byte <= img[i];
      file_bytes.last_byte <= (i == img.size() - 1);
      do @(posedge clk); while (!file_bytes.ready);
      burst_left--;
    end
    files_sent++;
    bytes_sent += img.size();
  endtask

  task automatic wait_for_verdicts();
    do begin
      @(negedge clk);
      file_bytes.valid <= 1'b0;
    end while (pending != 0);
  endtask

  initial begin
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Timeout after %0d cycles, %0d verdicts outstanding", cycles, pending);
    $display("Verification failed");
    $finish;
  end

  initial begin
    logic [31:0] ptr;
    logic [15:0] mach;
    logic [31:0] cpu;
    logic [7:0]  cls;
    logic [7:0]  order;
    int          len;
    int          k;
    int          sel;
    rst = 1'b1;
    file_bytes.valid = 1'b0;
    file_bytes.data_byte = 8'h00;
    file_bytes.last_byte = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: every format and arch, boundary sizes and offsets
    make_elf(ELF_CLASS64, ELF_DATA_LE, ELF_M_AMD64, 20); send_file();
    make_elf(ELF_CLASS32, ELF_DATA_LE, ELF_M_386, 24);   send_file();
    make_elf(ELF_CLASS32, ELF_DATA_BE, ELF_M_ARM, 20);   send_file();
    make_elf(ELF_CLASS64, ELF_DATA_BE, ELF_M_A64, 22);   send_file();
    make_elf(ELF_CLASS64, ELF_DATA_LE, ELF_M_RV, 20);    send_file();
    make_elf(ELF_CLASS32, ELF_DATA_BE, ELF_M_RV, 20);    send_file();
    make_elf(8'hFF, 8'h00, 16'hFFFF, 20);                send_file();
    make_elf(ELF_CLASS64, ELF_DATA_LE, ELF_M_AMD64, 19); send_file();
    make_pe(PE_MIN_OFF32, PE_M_I386, 70);                send_file();
    make_pe(32'h80, PE_M_AMD64, 32'h86 + 3);             send_file();
    make_pe(32'h44, PE_M_ARM, 32'h4A);                   send_file();
    make_pe(32'h50, PE_M_ARM64, 32'h58);                 send_file();
    make_pe(32'h40, 16'h0000, 72);                       send_file();
    make_pe(PE_MIN_OFF32 - 1, PE_M_I386, 72);            send_file();
    make_pe(PE_MIN_OFF32, PE_M_I386, 69);                send_file();
    make_pe(PE_LIMIT, PE_M_AMD64, 80);                   send_file();
    make_pe(32'hFFFFFFFF, PE_M_AMD64, 64);               send_file();
    make_pe(32'h48, PE_M_I386, 80);
    put(32'h4B, 8'hFF);                                  send_file();
    make_pe(32'h40, PE_M_I386, 63);                      send_file();
    make_macho(MH_MAGIC, CPU_X86, 8);                    send_file();
    make_macho(MH_MAGIC, CPU_ARM, 9);                    send_file();
    make_macho(MH_CIGAM, 32'h0C000000, 8);               send_file();
    make_macho(MH_MAGIC_64, CPU_X86_64, 8);              send_file();
    make_macho(MH_MAGIC_64, CPU_ARM64, 12);              send_file();
    make_macho(MH_CIGAM_64, 32'hFFFFFFFF, 8);            send_file();
    make_macho(FAT_MAGIC, 32'h0, 8);                     send_file();
    make_macho(FAT_CIGAM, 32'h0, 10);                    send_file();
    make_macho(MH_MAGIC, CPU_X86, 7);                    send_file();
    img = {8'h00};                                       send_file();
    img = {8'hFF};                                       send_file();
    wait_for_verdicts();

    // random: mostly well-formed headers with random content, some broken or noise
    while (bytes_sent < BYTE_TARGET || files_sent < FILE_TARGET) begin
      sel = $urandom_range(0, 9);
      if (sel <= 2) begin
        cls = ($urandom_range(0, 3) == 0) ? 8'($urandom) :
              ($urandom_range(0, 1) ? ELF_CLASS64 : ELF_CLASS32);
        order = ($urandom_range(0, 3) == 0) ? 8'($urandom) :
                ($urandom_range(0, 1) ? ELF_DATA_LE : ELF_DATA_BE);
        mach = ($urandom_range(0, 4) == 0) ? 16'($urandom) :
               elf_machines[$urandom_range(0, 4)];
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 19) : $urandom_range(20, 32);
        make_elf(cls, order, mach, len);
      end else if (sel <= 4) begin
        ptr = PE_MIN_OFF32 + $urandom_range(0, 40);
        mach = ($urandom_range(0, 4) == 0) ? 16'($urandom) :
               pe_machines[$urandom_range(0, 3)];
        len = ptr + 6 + $urandom_range(0, 8);
        k = $urandom_range(0, 11);
        case (k)
          0: len = ptr + $urandom_range(0, 5);
          1: ptr = $urandom_range(0, PE_MIN_OFF32 - 1);
          2: ptr = PE_LIMIT + $urandom_range(1, 1000);
          default: ;
        endcase
        make_pe(ptr, mach, len);
        if (k == 3) begin
          k = $urandom_range(0, 3);
          put(longint'(ptr) + k, ~PE_SIG[8*k +: 8]);
        end
      end else if (sel <= 7) begin
        cpu = ($urandom_range(0, 3) == 0) ? $urandom : macho_cpus[$urandom_range(0, 3)];
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 7) : $urandom_range(8, 16);
        make_macho(macho_magics[$urandom_range(0, 5)], cpu, len);
      end else begin
        fill_random($urandom_range(1, 24));
      end
      send_file();
      if ($urandom_range(0, 19) == 0) wait_for_verdicts();
    end

    wait_for_verdicts();
    repeat (10) @(negedge clk);
    $display("Streamed %0d files (%0d bytes): ELF, PE, thin and fat Mach-O,",
             files_sent, bytes_sent);
    $display("  truncated files, bad offsets and noise; compared %0d verdicts, %0d mismatches",
             checked, fail_count);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
